FILE: hw/rtl/ifsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifsr_pkg: shared types and constants of the in-flight slot ring
// Slot lifecycle codes, operation codes and the state/result bundles that
// travel between the top level and the operation logic.
// ----------------------------------------------------------------------------
package ifsr_pkg;

	// Number of slots built into the ring.
	localparam int MAX_SLOTS = 3;

	localparam int DEPTH_W = 2;
	localparam int IDX_W   = 2;
	localparam int TICK_W  = 64;
	localparam int WAKE_W  = 32;
	localparam int FUNC_W  = 3;
	localparam int OFF_W   = 3;

	localparam logic [DEPTH_W-1:0] MAX_DEPTH   = DEPTH_W'(MAX_SLOTS);
	localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(2);

	// Lifecycle of one slot.
	typedef enum logic [1:0] {
		PH_EMPTY      = 2'd0,
		PH_DISPATCHED = 2'd1,
		PH_FENCE_DONE = 2'd2,
		PH_TAIL       = 2'd3
	} phase_t;

	// Operation codes of one request.
	typedef enum logic [FUNC_W-1:0] {
		FN_ALLOCATE   = 3'd0,
		FN_FENCE_DONE = 3'd1,
		FN_TO_TAIL    = 3'd2,
		FN_LOCATE     = 3'd3,
		FN_READ_TAIL  = 3'd4,
		FN_PAUSE      = 3'd5,
		FN_RESUME     = 3'd6,
		FN_CLEAR_WAKE = 3'd7
	} func_t;

	// Architectural state of the ring.
	typedef struct packed {
		phase_t [MAX_SLOTS-1:0]              phase;
		logic   [MAX_SLOTS-1:0][TICK_W-1:0]  tick;
		logic   [IDX_W-1:0]                  cursor;
		logic                                ever_alloc;
		logic                                paused;
		logic   [WAKE_W-1:0]                 wake;
	} ring_state_t;

	// Result of one request.
	typedef struct packed {
		logic               ok;
		logic [IDX_W-1:0]   slot;
		logic [TICK_W-1:0]  tick;
		logic               paused;
		logic               quiet;
		logic [WAKE_W-1:0]  wake;
	} ring_result_t;

endpackage

FILE: hw/rtl/ifsr_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifsr_step: operation logic of the in-flight slot ring
// Works out the next ring state and the result of one request from the
// current state, the configured depth and the request fields.
// ----------------------------------------------------------------------------
module ifsr_step import ifsr_pkg::*; (
	input  ring_state_t          cur_st,
	input  logic [DEPTH_W-1:0]   cfg_depth,
	input  logic [FUNC_W-1:0]    func,
	input  logic [TICK_W-1:0]    tick_stamp,
	input  logic [IDX_W-1:0]     slot_sel,
	input  logic [OFF_W-1:0]     slot_rel,
	output ring_state_t          nxt_st,
	output ring_result_t         res
);

	logic [DEPTH_W-1:0] depth;
	logic               depth_zero;
	logic [IDX_W-1:0]   cursor;
	phase_t             ph_cursor;
	logic               idx_ok;
	phase_t             ph_index;
	logic [IDX_W-1:0]   recent;
	logic               off_pos;
	logic [3:0]         reach;
	logic               off_ok;
	logic               loc_ok;
	logic [3:0]         tsum;
	logic [3:0]         tsub;
	logic [IDX_W-1:0]   target;
	phase_t             ph_target;
	logic               quiet;

	// Depth saturates at the slot count; zero means unconfigured.
	assign depth      = (cfg_depth > MAX_DEPTH) ? MAX_DEPTH : cfg_depth;
	assign depth_zero = (depth == '0);

	// Cursor reduced modulo the depth; it never exceeds twice the depth.
	always_comb begin
		if (depth == DEPTH_W'(1)) begin
			cursor = '0;
		end else if (cur_st.cursor >= depth) begin
			cursor = cur_st.cursor - depth;
		end else begin
			cursor = cur_st.cursor;
		end
	end

	assign ph_cursor = (cursor < IDX_W'(MAX_SLOTS)) ? cur_st.phase[cursor] : PH_EMPTY;
	assign idx_ok    = (slot_sel < depth);
	assign ph_index  = idx_ok ? cur_st.phase[slot_sel] : PH_EMPTY;

	// The newest slot sits just behind the cursor.
	assign recent = (cursor == '0) ? (depth - DEPTH_W'(1)) : (cursor - IDX_W'(1));

	// Offset must lie in (-depth, 0].
	assign off_pos = !slot_rel[OFF_W-1] && (slot_rel != '0);
	assign reach   = {2'b00, depth} + {slot_rel[OFF_W-1], slot_rel};
	assign off_ok  = !off_pos && !reach[3] && (reach != '0);
	assign loc_ok  = !depth_zero && off_ok && cur_st.ever_alloc;

	// Target slot: the sum stays below twice the depth, so one subtract.
	assign tsum   = {2'b00, recent} + {2'b00, depth} + {slot_rel[OFF_W-1], slot_rel};
	assign tsub   = tsum - {2'b00, depth};
	assign target = (tsum >= {2'b00, depth}) ? tsub[IDX_W-1:0] : tsum[IDX_W-1:0];
	assign ph_target = (target < IDX_W'(MAX_SLOTS)) ? cur_st.phase[target] : PH_EMPTY;

	// Apply the operation.
	always_comb begin
		nxt_st   = cur_st;
		res.ok   = 1'b0;
		res.slot = '0;
		res.tick = '0;
		case (func_t'(func))
			FN_ALLOCATE: begin
				if (!depth_zero && !cur_st.paused &&
						(ph_cursor == PH_EMPTY || ph_cursor == PH_TAIL)) begin
					nxt_st.tick[cursor]  = tick_stamp;
					nxt_st.phase[cursor] = PH_DISPATCHED;
					nxt_st.cursor        = (cursor == depth - DEPTH_W'(1)) ?
						'0 : (cursor + IDX_W'(1));
					nxt_st.ever_alloc    = 1'b1;
					res.ok               = 1'b1;
					res.slot             = cursor;
				end
			end
			FN_FENCE_DONE: begin
				if (idx_ok && ph_index == PH_DISPATCHED) begin
					nxt_st.phase[slot_sel] = PH_FENCE_DONE;
					res.ok                 = 1'b1;
				end
			end
			FN_TO_TAIL: begin
				if (idx_ok && ph_index == PH_FENCE_DONE) begin
					nxt_st.phase[slot_sel] = PH_TAIL;
					nxt_st.wake            = cur_st.wake + WAKE_W'(1);
					res.ok                 = 1'b1;
				end
			end
			FN_LOCATE: begin
				if (loc_ok) begin
					res.ok   = 1'b1;
					res.slot = target;
				end
			end
			FN_READ_TAIL: begin
				if (loc_ok && (ph_target == PH_TAIL || ph_target == PH_FENCE_DONE)) begin
					res.ok   = 1'b1;
					res.tick = cur_st.tick[target];
				end
			end
			FN_PAUSE: begin
				if (!depth_zero) begin
					nxt_st.paused = 1'b1;
					res.ok        = 1'b1;
				end
			end
			FN_RESUME: begin
				if (!depth_zero) begin
					nxt_st.paused = 1'b0;
					res.ok        = 1'b1;
				end
			end
			default: begin
				nxt_st.wake = '0;
				res.ok      = 1'b1;
			end
		endcase

		// Quiescent when no slot in use is still in flight after the operation.
		quiet = !depth_zero;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			if ((DEPTH_W'(i) < depth) &&
					(nxt_st.phase[i] == PH_DISPATCHED || nxt_st.phase[i] == PH_FENCE_DONE)) begin
				quiet = 1'b0;
			end
		end

		res.paused = nxt_st.paused;
		res.quiet  = quiet;
		res.wake   = nxt_st.wake;
	end

endmodule

FILE: hw/rtl/in_flight_slot_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// in_flight_slot_ring: ring of in-flight work slots
// Allocates, advances and looks up slots of a small ring and reports the
// pause flag, quiescence and wake count with every result.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid / in_stall    func, tick_stamp, slot_sel, slot_rel
//  out       out_valid / out_stall  ok, result_slot, tick_out, is_paused,
//                                   is_idle, wake_count
//  cfg       cfg_we                 cfg_wdata (ring depth)
//
// One request per cycle is sustained while the output is not stalled. A
// request passes from the input register into the result register, where
// out_valid rises. The ring state updates as a request moves into the
// result register. A stalled output holds the result and, once the input
// register is also full, stalls the input. Reset empties every slot,
// clears the cursor, pause flag and wake count, and sets the depth to two.
// ----------------------------------------------------------------------------
module in_flight_slot_ring import ifsr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [DEPTH_W-1:0]   cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [FUNC_W-1:0]    func,
	input  logic [TICK_W-1:0]    tick_stamp,
	input  logic [IDX_W-1:0]     slot_sel,
	input  logic signed [OFF_W-1:0] slot_rel,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 ok,
	output logic [IDX_W-1:0]     result_slot,
	output logic [TICK_W-1:0]    tick_out,
	output logic                 is_paused,
	output logic                 is_idle,
	output logic [WAKE_W-1:0]    wake_count
);

	logic               valid_s1;
	logic [FUNC_W-1:0]  func_s1;
	logic [TICK_W-1:0]  tick_s1;
	logic [IDX_W-1:0]   index_s1;
	logic [OFF_W-1:0]   offset_s1;
	logic [DEPTH_W-1:0] depth_q;
	ring_state_t        ring_q;
	ring_state_t        ring_nxt;
	ring_result_t       res;
	ring_result_t       res_q;
	logic               out_valid_q;
	logic               advance;

	// A request moves on when the result register is free or being drained.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Depth register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_RESET;
		end else if (cfg_we) begin
			depth_q <= cfg_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1   <= func;
			tick_s1   <= tick_stamp;
			index_s1  <= slot_sel;
			offset_s1 <= slot_rel;
		end
	end

	// Operation logic.
	ifsr_step u_step (
		.cur_st      (ring_q),
		.cfg_depth   (depth_q),
		.func        (func_s1),
		.tick_stamp  (tick_s1),
		.slot_sel    (index_s1),
		.slot_rel    (offset_s1),
		.nxt_st      (ring_nxt),
		.res         (res)
	);

	// Ring state commits as the request enters the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q <= '0;
		end else if (advance) begin
			ring_q <= ring_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign ok           = res_q.ok;
	assign result_slot  = res_q.slot;
	assign tick_out     = res_q.tick;
	assign is_paused    = res_q.paused;
	assign is_idle      = res_q.quiet;
	assign wake_count   = res_q.wake;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the in-flight slot ring
// A queue of requests feeds a valid/stall driver. Every accepted request is
// run through a local copy of the ring's behavior, and each result taken
// from the block is checked field by field against the oldest prediction.
// The run covers directed corner cases and several depth settings with
// random traffic, with random gaps on both channels in all but the last phase.
// ----------------------------------------------------------------------------
module testbench;
	import ifsr_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;

	// One request as the driver presents it.
	typedef struct packed {
		func_t               op;
		logic [TICK_W-1:0]   tick;
		logic [IDX_W-1:0]    idx;
		logic [OFF_W-1:0]    offs;
	} ring_request_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [DEPTH_W-1:0]     cfg_wdata = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [FUNC_W-1:0]      func = '0;
	logic [TICK_W-1:0]      tick_stamp = '0;
	logic [IDX_W-1:0]       slot_sel = '0;
	logic signed [OFF_W-1:0] slot_rel = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   ok;
	logic [IDX_W-1:0]       result_slot;
	logic [TICK_W-1:0]      tick_out;
	logic                   is_paused;
	logic                   is_idle;
	logic [WAKE_W-1:0]      wake_count;

	in_flight_slot_ring i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.tick_stamp   (tick_stamp),
		.slot_sel     (slot_sel),
		.slot_rel     (slot_rel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.ok           (ok),
		.result_slot  (result_slot),
		.tick_out     (tick_out),
		.is_paused    (is_paused),
		.is_idle      (is_idle),
		.wake_count   (wake_count)
	);

	// Clock generation.
	initial begin
		forever #5 clk = ~clk;
	end

	// Local copy of the ring state and its depth register.
	phase_t              ph_q [MAX_SLOTS];
	logic [TICK_W-1:0]   stamp_q [MAX_SLOTS];
	logic [IDX_W-1:0]    cursor_q;
	logic                allocated_q;
	logic                paused_q;
	logic [WAKE_W-1:0]   wakes_q;
	logic [DEPTH_W-1:0]  depth_q;

	ring_request_t pending_reqs [$];
	ring_result_t  predicted_results [$];

	bit  gaps_on = 1'b1;
	bit  in_fire = 1'b0;
	int  mismatches = 0;
	int  n_sent = 0;
	int  n_checked = 0;
	int  n_ok = 0;
	int  n_cfg = 0;
	int  idle_cycles = 0;

	// Resolves a relative offset to a slot; refused before any allocation.
	function automatic bit find_slot(input logic signed [OFF_W-1:0] offs, input int d,
			output int tgt);
		int o;
		int recent;
		o = int'(offs);
		tgt = 0;
		if (d == 0 || o > 0 || o <= -d || !allocated_q)
			return 1'b0;
		recent = (int'(cursor_q) % d + d - 1) % d;
		tgt = (recent + d + o) % d;
		return 1'b1;
	endfunction

	// Applies one request to the local ring state and returns its result.
	function automatic ring_result_t ring_apply(input ring_request_t rq);
		ring_result_t r;
		int d;
		int c;
		int tgt;
		int sidx;
		r = '0;
		d = int'(depth_q);
		sidx = int'(rq.idx);
		case (rq.op)
			FN_ALLOCATE: begin
				if (d != 0 && !paused_q) begin
					c = int'(cursor_q) % d;
					if (ph_q[c] == PH_EMPTY || ph_q[c] == PH_TAIL) begin
						stamp_q[c] = rq.tick;
						ph_q[c] = PH_DISPATCHED;
						cursor_q = IDX_W'((c + 1) % d);
						allocated_q = 1'b1;
						r.ok = 1'b1;
						r.slot = IDX_W'(c);
					end
				end
			end
			FN_FENCE_DONE: begin
				if (sidx < d && ph_q[sidx] == PH_DISPATCHED) begin
					ph_q[sidx] = PH_FENCE_DONE;
					r.ok = 1'b1;
				end
			end
			FN_TO_TAIL: begin
				if (sidx < d && ph_q[sidx] == PH_FENCE_DONE) begin
					ph_q[sidx] = PH_TAIL;
					wakes_q = wakes_q + WAKE_W'(1);
					r.ok = 1'b1;
				end
			end
			FN_LOCATE: begin
				if (find_slot($signed(rq.offs), d, tgt)) begin
					r.ok = 1'b1;
					r.slot = IDX_W'(tgt);
				end
			end
			FN_READ_TAIL: begin
				if (find_slot($signed(rq.offs), d, tgt)) begin
					if (ph_q[tgt] == PH_TAIL || ph_q[tgt] == PH_FENCE_DONE) begin
						r.ok = 1'b1;
						r.tick = stamp_q[tgt];
					end
				end
			end
			FN_PAUSE: begin
				if (d != 0) begin
					paused_q = 1'b1;
					r.ok = 1'b1;
				end
			end
			FN_RESUME: begin
				if (d != 0) begin
					paused_q = 1'b0;
					r.ok = 1'b1;
				end
			end
			default: begin
				wakes_q = '0;
				r.ok = 1'b1;
			end
		endcase
		r.quiet = (d != 0);
		for (int i = 0; i < d; i++) begin
			if (ph_q[i] == PH_DISPATCHED || ph_q[i] == PH_FENCE_DONE)
				r.quiet = 1'b0;
		end
		r.paused = paused_q;
		r.wake = wakes_q;
		return r;
	endfunction

	function automatic ring_request_t make_req(input func_t op, input logic [TICK_W-1:0] tick,
			input int idx, input int offs);
		ring_request_t rq;
		rq.op = op;
		rq.tick = tick;
		rq.idx = IDX_W'(idx);
		rq.offs = OFF_W'(offs);
		return rq;
	endfunction

	// Random request biased toward the slot lifecycle and in-range operands.
	function automatic ring_request_t random_req(input int d);
		ring_request_t rq;
		int w;
		int top;
		w = $urandom_range(0, 99);
		top = (d == 0) ? 2 : d - 1;
		if (w < 26)
			rq.op = FN_ALLOCATE;
		else if (w < 46)
			rq.op = FN_FENCE_DONE;
		else if (w < 64)
			rq.op = FN_TO_TAIL;
		else if (w < 74)
			rq.op = FN_LOCATE;
		else if (w < 86)
			rq.op = FN_READ_TAIL;
		else if (w < 91)
			rq.op = FN_PAUSE;
		else if (w < 97)
			rq.op = FN_RESUME;
		else
			rq.op = FN_CLEAR_WAKE;
		rq.tick = {$urandom, $urandom};
		if ($urandom_range(0, 9) == 0)
			rq.idx = IDX_W'($urandom_range(0, 3));
		else
			rq.idx = IDX_W'($urandom_range(0, top));
		if ($urandom_range(0, 4) == 0)
			rq.offs = OFF_W'($urandom_range(0, 7));
		else
			rq.offs = OFF_W'(-int'($urandom_range(0, (d == 0) ? 0 : d - 1)));
		return rq;
	endfunction

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// Request driver: presents queued requests with random gaps between them.
	int in_gap = 0;
	ring_request_t drv_req;
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				drv_req = pending_reqs.pop_front();
				func <= drv_req.op;
				tick_stamp <= drv_req.tick;
				slot_sel <= drv_req.idx;
				slot_rel <= drv_req.offs;
				in_valid <= 1'b1;
				if (gaps_on && $urandom_range(0, 3) == 0)
					in_gap = $urandom_range(1, 3);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result-side stall in random bursts.
	int stall_left = 0;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (gaps_on && arst_n && $urandom_range(0, 6) == 0) begin
			stall_left = $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor: predicts accepted requests, checks accepted results, and
	// stops the run if the channels go quiet for too long.
	ring_result_t want;
	bit took_in;
	bit took_out;
	always @(posedge clk) begin
		if (arst_n) begin
			took_in = in_valid && !in_stall;
			took_out = out_valid && !out_stall;
			in_fire <= took_in;
			if (took_out) begin
				if (predicted_results.size() == 0) begin
					$error("result arrived with no request outstanding");
					mismatches++;
				end else begin
					want = predicted_results.pop_front();
					compare_field("ok", want.ok, ok);
					compare_field("result_slot", want.slot, result_slot);
					compare_field("tick_out", want.tick, tick_out);
					compare_field("is_paused", want.paused, is_paused);
					compare_field("is_idle", want.quiet, is_idle);
					compare_field("wake_count", want.wake, wake_count);
					n_checked++;
					if (want.ok)
						n_ok++;
				end
			end
			if (took_in) begin
				predicted_results.push_back(ring_apply(make_req(func_t'(func), tick_stamp,
					int'(slot_sel), int'(slot_rel))));
				n_sent++;
			end
			if (took_in || took_out)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Waits until every queued request has been taken and answered.
	task automatic drain();
		while (pending_reqs.size() > 0 || in_valid || predicted_results.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_depth(input int d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= DEPTH_W'(d);
		@(negedge clk);
		cfg_we <= 1'b0;
		depth_q = DEPTH_W'(d);
		n_cfg++;
	endtask

	// Sequencer: reset, directed requests, then random phases at each depth.
	int depth_plan [8] = '{3, 1, 0, 2, 3, 2, 1, 3};
	initial begin
		for (int i = 0; i < MAX_SLOTS; i++) begin
			ph_q[i] = PH_EMPTY;
			stamp_q[i] = '0;
		end
		cursor_q = '0;
		allocated_q = 1'b0;
		paused_q = 1'b0;
		wakes_q = '0;
		depth_q = DEPTH_RESET;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset depth of two.
		pending_reqs.push_back(make_req(FN_LOCATE, '0, 0, 0));
		pending_reqs.push_back(make_req(FN_READ_TAIL, '0, 0, 0));
		pending_reqs.push_back(make_req(FN_FENCE_DONE, '0, 0, 0));
		pending_reqs.push_back(make_req(FN_ALLOCATE, '0, 0, 0));
		pending_reqs.push_back(make_req(FN_ALLOCATE, '1, 0, 0));
		pending_reqs.push_back(make_req(FN_ALLOCATE, 64'h1234, 0, 0));
		pending_reqs.push_back(make_req(FN_LOCATE, '0, 0, 0));
		pending_reqs.push_back(make_req(FN_LOCATE, '0, 0, -1));
		pending_reqs.push_back(make_req(FN_LOCATE, '0, 0, -2));
		pending_reqs.push_back(make_req(FN_LOCATE, '0, 0, 1));
		pending_reqs.push_back(make_req(FN_LOCATE, '0, 0, -4));
		pending_reqs.push_back(make_req(FN_READ_TAIL, '0, 0, 0));
		pending_reqs.push_back(make_req(FN_TO_TAIL, '0, 1, 0));
		pending_reqs.push_back(make_req(FN_FENCE_DONE, '0, 1, 0));
		pending_reqs.push_back(make_req(FN_READ_TAIL, '0, 3, 0));
		pending_reqs.push_back(make_req(FN_TO_TAIL, '0, 1, 0));
		pending_reqs.push_back(make_req(FN_FENCE_DONE, '0, 2, 0));
		pending_reqs.push_back(make_req(FN_FENCE_DONE, '1, 3, 3));
		pending_reqs.push_back(make_req(FN_PAUSE, '0, 0, 0));
		pending_reqs.push_back(make_req(FN_ALLOCATE, 64'h55, 0, 0));
		pending_reqs.push_back(make_req(FN_RESUME, '0, 0, 0));
		pending_reqs.push_back(make_req(FN_FENCE_DONE, '0, 0, 0));
		pending_reqs.push_back(make_req(FN_TO_TAIL, '0, 0, 0));
		pending_reqs.push_back(make_req(FN_ALLOCATE, {$urandom, $urandom}, 0, 0));
		pending_reqs.push_back(make_req(FN_CLEAR_WAKE, '0, 0, 0));
		pending_reqs.push_back(make_req(FN_READ_TAIL, '0, 0, -1));
		drain();

		// Random phases; the depth changes only while the ring is idle.
		foreach (depth_plan[p]) begin
			if (p == $size(depth_plan) - 1)
				gaps_on = 1'b0;
			write_depth(depth_plan[p]);
			for (int k = 0; k < ((depth_plan[p] == 0) ? 60 : 240); k++)
				pending_reqs.push_back(random_req(depth_plan[p]));
			drain();
		end

		$display("Checked %0d results for %0d requests (%0d succeeded)", n_checked, n_sent,
			n_ok);
		$display("Depth register written %0d times, covering depths zero through three",
			n_cfg);
		if (mismatches == 0 && predicted_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
